[src/hes_pkg.sv]
// Shared constants, types and the arctangent table of the heading error steering core.
`timescale 1ns / 1ps

package hes_pkg;

	localparam int CORDIC_STAGES = 16;

	// CORDIC datapath: the 34-bit quaternion terms, negated and grown by the CORDIC gain.
	localparam int CW = 37;
	// Angle accumulator, units of 2^-20 rad
	localparam int ZW = 24;
	// Q3.12 angles
	localparam int AW = 16;

	localparam int ADDR_W = 3;
	localparam logic REG_SPEED_CMD = 1'b0;

	localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
	localparam logic signed [AW-1:0] PI_Q12 = 16'sd12868;
	localparam logic signed [AW:0] TWO_PI_Q12 = 17'sd25736;
	localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

	typedef struct packed {
		logic valid;
		logic zero;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_vec_t;

	// round(atan(2^-i) * 2^20)
	function automatic logic signed [ZW-1:0] atan_val(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 24'sd823550;
			1: v = 24'sd486170;
			2: v = 24'sd256879;
			3: v = 24'sd130396;
			4: v = 24'sd65451;
			5: v = 24'sd32757;
			6: v = 24'sd16383;
			7: v = 24'sd8192;
			8: v = 24'sd4096;
			9: v = 24'sd2048;
			10: v = 24'sd1024;
			11: v = 24'sd512;
			12: v = 24'sd256;
			13: v = 24'sd128;
			14: v = 24'sd64;
			15: v = 24'sd32;
			16: v = 24'sd16;
			17: v = 24'sd8;
			18: v = 24'sd4;
			19: v = 24'sd2;
			20: v = 24'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[src/hes_cordic.sv]
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
`timescale 1ns / 1ps

module hes_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  hes_pkg::cordic_vec_t vec_in,
	output hes_pkg::cordic_vec_t vec_out
);

	hes_pkg::cordic_vec_t pipe_s [1:hes_pkg::CORDIC_STAGES];

	assign vec_out = pipe_s[hes_pkg::CORDIC_STAGES];

	for (genvar i = 0; i < hes_pkg::CORDIC_STAGES; i++) begin : g_stage
		hes_pkg::cordic_vec_t cur;
		hes_pkg::cordic_vec_t nxt;
		logic signed [hes_pkg::CW-1:0] xs;
		logic signed [hes_pkg::CW-1:0] ys;

		if (i == 0) begin : g_first
			assign cur = vec_in;
		end else begin : g_next
			assign cur = pipe_s[i];
		end

		always_comb begin
			xs = cur.x >>> i;
			ys = cur.y >>> i;
			nxt = cur;
			if (!cur.y[hes_pkg::CW-1]) begin
				nxt.x = cur.x + ys;
				nxt.y = cur.y - xs;
				nxt.z = cur.z + hes_pkg::atan_val(i);
			end else begin
				nxt.x = cur.x - ys;
				nxt.y = cur.y + xs;
				nxt.z = cur.z - hes_pkg::atan_val(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_s[i+1] <= '0;
			end else if (en) begin
				pipe_s[i+1] <= nxt;
			end
		end
	end

endmodule

[src/heading_error_steering_core.sv]
// Top level: pose and target in, proportional steering command out.
// An input transfer passes s1, the CORDIC input registers, the CORDIC stages, s3, s4 and the output buffer.
// Throughput: one item per cycle while the output buffer has room, set by the unrolled CORDIC pipelines.
// A two-entry output buffer keeps s_tready high while one result waits.
// Reset (arst_n low, asynchronous) clears all valid bits, the buffer occupancy and the speed register.
`timescale 1ns / 1ps

module heading_error_steering_core (
	input  logic                      clk,
	input  logic                      arst_n,
	// robot_x, robot_y, quat_w, quat_x, quat_y, quat_z, target_x, target_y
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [191:0]              s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// angular_rate, forward_speed
	output logic [31:0]               m_tdata,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hes_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	logic [15:0] speed_cmd_q;
	logic        sel_speed;

	assign pready = 1'b1;
	assign sel_speed = (paddr[2] == hes_pkg::REG_SPEED_CMD);
	assign prdata = sel_speed ? {16'd0, speed_cmd_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_cmd_q <= '0;
		end else if (psel && penable && pwrite && sel_speed) begin
			speed_cmd_q <= pwdata[15:0];
		end
	end

	// output buffer occupancy; pipeline moves whenever there is room
	logic [1:0] cnt_q;
	logic       adv;
	assign adv = (cnt_q != 2'd2);
	assign s_tready = adv;

	logic signed [31:0] rx, ry, tx, ty;
	logic signed [15:0] qw, qx, qy, qz;
	assign rx = s_tdata[31:0];
	assign ry = s_tdata[63:32];
	assign qw = s_tdata[79:64];
	assign qx = s_tdata[95:80];
	assign qy = s_tdata[111:96];
	assign qz = s_tdata[127:112];
	assign tx = s_tdata[159:128];
	assign ty = s_tdata[191:160];

	// s1: differences and quaternion products
	logic               v_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [31:0] wz_s1, xy_s1, yy_s1, zz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= 33'(tx) - 33'(rx);
			dy_s1 <= 33'(ty) - 33'(ry);
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
		end
	end

	// s2: sine and cosine terms, left half plane folded over
	logic signed [33:0] siny, cosy;
	hes_pkg::cordic_vec_t brg_in, yaw_in, brg_pre, yaw_pre, brg_out, yaw_out;

	assign siny = (34'(wz_s1) + 34'(xy_s1)) <<< 1;
	assign cosy = hes_pkg::ONE_Q28 - ((34'(yy_s1) + 34'(zz_s1)) <<< 1);

	function automatic hes_pkg::cordic_vec_t prerotate(input logic signed [hes_pkg::CW-1:0] x,
	                                                    input logic signed [hes_pkg::CW-1:0] y,
	                                                    input logic vld);
		hes_pkg::cordic_vec_t r;
		r.valid = vld;
		r.zero = (x == '0) && (y == '0);
		r.x = x;
		r.y = y;
		r.z = '0;
		if (x[hes_pkg::CW-1]) begin
			r.x = -x;
			r.y = -y;
			r.z = y[hes_pkg::CW-1] ? -hes_pkg::PI_Q20 : hes_pkg::PI_Q20;
		end
		return r;
	endfunction

	assign brg_pre = prerotate(hes_pkg::CW'(dx_s1), hes_pkg::CW'(dy_s1), v_s1);
	assign yaw_pre = prerotate(hes_pkg::CW'(cosy), hes_pkg::CW'(siny), v_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brg_in <= '0;
			yaw_in <= '0;
		end else if (adv) begin
			brg_in <= brg_pre;
			yaw_in <= yaw_pre;
		end
	end

	hes_cordic u_cordic_bearing (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vec_in  (brg_in),
		.vec_out (brg_out)
	);

	hes_cordic u_cordic_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vec_in  (yaw_in),
		.vec_out (yaw_out)
	);

	// s3: round to Q3.12 half up and clamp to +-pi; a zero vector gives zero
	function automatic logic signed [hes_pkg::AW-1:0] to_q12(input hes_pkg::cordic_vec_t v);
		logic signed [hes_pkg::ZW-1:0] zr;
		logic signed [hes_pkg::AW-1:0] q;
		zr = (v.z + hes_pkg::ZW'(128)) >>> 8;
		q = zr[hes_pkg::AW-1:0];
		if (zr > hes_pkg::ZW'(hes_pkg::PI_Q12))
			q = hes_pkg::PI_Q12;
		else if (zr < -hes_pkg::ZW'(hes_pkg::PI_Q12))
			q = -hes_pkg::PI_Q12;
		if (v.zero)
			q = '0;
		return q;
	endfunction

	logic                           v_s3;
	logic signed [hes_pkg::AW-1:0] brg_s3, yaw_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= brg_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			brg_s3 <= to_q12(brg_out);
			yaw_s3 <= to_q12(yaw_out);
		end
	end

	// s4: heading error wrapped into [-pi, pi]
	logic signed [hes_pkg::AW:0] err, err_w;
	logic                        v_s4;
	logic signed [hes_pkg::AW:0] err_s4;

	assign err = 17'(brg_s3) - 17'(yaw_s3);

	always_comb begin
		err_w = err;
		if (err > 17'(hes_pkg::PI_Q12))
			err_w = err - hes_pkg::TWO_PI_Q12;
		else if (err < -17'(hes_pkg::PI_Q12))
			err_w = err + hes_pkg::TWO_PI_Q12;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s4 <= err_w;
		end
	end

	// rate = floor((3e + 1) / 2)
	logic signed [18:0] rate3;
	logic [31:0]        result;
	assign rate3 = ((19'(err_s4) <<< 1) + 19'(err_s4) + 19'sd1) >>> 1;
	assign result = {speed_cmd_q, rate3[15:0]};

	// two-entry output buffer, head in buf0_q
	logic        push, pop;
	logic [31:0] buf0_q, buf1_q;

	assign push = adv && v_s4;
	assign pop = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata = buf0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push)
					buf0_q <= result;
			end
			2'd1: begin
				if (push && pop)
					buf0_q <= result;
				else if (push)
					buf1_q <= result;
			end
			2'd2: begin
				if (pop)
					buf0_q <= buf1_q;
			end
			default: begin
				buf0_q <= buf0_q;
			end
		endcase
	end

endmodule

[src/hes_checker.sv]
// Port-level assertions for the heading error steering core, bound to the top level.
`timescale 1ns / 1ps

module hes_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [31:0]                m_tdata,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [hes_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata,
	input logic                       pready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// rate stays within 1.5 pi
	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd19302)
			&& ($signed(m_tdata[15:0]) >= -16'sd19302))
		else $error("angular rate out of range");

	// register write reads back on the next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && !paddr[2] |=>
			paddr[2] || (prdata[15:0] == $past(pwdata[15:0])))
		else $error("speed register readback mismatch");

	// with nothing left to drain, input is always taken
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind heading_error_steering_core hes_checker u_hes_checker (.*);
